// File: rtl/core/pnr_pkg.sv
package pnr_pkg;

  // Q16.32 word width and the number of coefficient registers.
  localparam int unsigned QW          = 48;
  localparam int unsigned NUM_COEF    = 6;
  localparam int unsigned MAX_DEG_DEF = 5;

  // Configuration register indexes.
  localparam logic [2:0] REG_COEF_0   = 3'd0;
  localparam logic [2:0] REG_ITER_CNT = 3'd6;

  localparam logic [7:0]    ITER_RESET = 8'd4;
  localparam logic [QW-1:0] Q_ONE      = 48'h0001_0000_0000;
  localparam logic [QW-1:0] Q_MAXV     = 48'h7FFF_FFFF_FFFF;
  localparam logic [QW-1:0] Q_MINV     = 48'h8000_0000_0000;
  // About 1e-5 in Q16.32.
  localparam logic [QW-1:0] DERIV_EPS  = 48'd42949;
  // Quotient cap during the long division.
  localparam logic [51:0]   QUO_CAP    = 52'h4_0000_0000_0000;
  // Index of the first divider step; the divider produces 80 quotient bits (48 + 32 fraction bits).
  localparam logic [6:0]    DIV_LAST   = 7'd79;
  localparam logic [6:0]    DIV_FRAC   = 7'd32;

  typedef struct packed {
    logic          sat;
    logic [QW-1:0] val;
  } sat_t;

  // Clip a signed value of up to 52 bits to the Q16.32 range.
  function automatic sat_t clip52(input logic signed [51:0] v);
    sat_t r;
    r.sat = 1'b0;
    r.val = v[QW-1:0];
    if (v > $signed({{4{1'b0}}, Q_MAXV})) begin
      r.sat = 1'b1;
      r.val = Q_MAXV;
    end else if (v < $signed({{4{1'b1}}, Q_MINV})) begin
      r.sat = 1'b1;
      r.val = Q_MINV;
    end
    return r;
  endfunction

  // Apply a sign to a magnitude and clip to the Q16.32 range.
  function automatic sat_t sign_clip(input logic [63:0] q, input logic neg);
    sat_t r;
    r.sat = 1'b0;
    r.val = q[QW-1:0];
    if (neg) begin
      if (q > {16'd0, Q_MINV}) begin
        r.sat = 1'b1;
        r.val = Q_MINV;
      end else begin
        r.val = QW'(-q[QW-1:0]);
      end
    end else if (q > {16'd0, Q_MAXV}) begin
      r.sat = 1'b1;
      r.val = Q_MAXV;
    end
    return r;
  endfunction

  // Magnitude of a two's complement word.
  function automatic logic [QW-1:0] mag(input logic [QW-1:0] a);
    return a[QW-1] ? QW'(-a) : a;
  endfunction

endpackage

// File: rtl/core/polynomial_newton_root_refiner_core.sv
// Channel  | Ports                                    | Handshake
// ---------+------------------------------------------+------------------------------
// input    | start_root_i                             | start_i high while busy_o low
// result   | refined_root_o, saturated_o              | done_o, one cycle, no stall
// config   | cfg_idx_i, cfg_wdata_i                   | cfg_we_i, written at once
//
// A root is refined by N Newton steps after a preparation pass that scales the
// derivative coefficients. Each product runs on the shared 24x24 multiplier and each
// quotient on the bit-serial divider. A step whose slope is at or below threshold
// skips the divider.
// Reset is asynchronous, active low; it clears the coefficients to zero and the
// step count to four. The result beat cannot be stalled; busy_o is high from the cycle
// after the start beat until the result beat, and a new start beat may be taken in the
// result cycle.
module polynomial_newton_root_refiner_core
  import pnr_pkg::*;
#(
  parameter int unsigned MAX_DEGREE = MAX_DEG_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [QW-1:0] start_root_i,
  output logic          done_o,
  output logic [QW-1:0] refined_root_o,
  output logic          saturated_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [QW-1:0] cfg_wdata_i
);

  localparam int unsigned TW = $clog2(MAX_DEGREE + 1);
  localparam logic [TW-1:0] TERM_LAST = TW'(MAX_DEGREE);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PREP = 9'b000000010,
    S_STEP = 9'b000000100,
    S_LOAD = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_MACC = 9'b000100000,
    S_CHK  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_UPD  = 9'b100000000
  } state_e;

  typedef enum logic [2:0] {
    OP_C = 3'b001,
    OP_D = 3'b010,
    OP_X = 3'b100
  } op_e;

  state_e state_q, state_d;
  op_e    op_q;
  logic   done_q;

  logic [QW-1:0] coef_q [NUM_COEF];
  logic [7:0]    iter_cnt_q;
  logic [QW-1:0] dc_q [MAX_DEGREE];

  logic [QW-1:0] x_q, xi_q, p_q, dp_q;
  logic          flag_q;
  logic [TW-1:0] term_q;
  logic [7:0]    step_q;

  // Multiplier operands and accumulator.
  logic [QW-1:0] ma_q, mb_q;
  logic          mneg_q;
  logic [1:0]    mk_q;
  logic [95:0]   acc_q;

  // Divider state.
  logic [QW-1:0] num_q, den_q, rem_q;
  logic [51:0]   quo_q;
  logic          big_q, dneg_q;
  logic [6:0]    dcnt_q;

  // Operand selection for the shared multiplier.
  logic [QW-1:0] coef_sel, dc_sel, opa, opb;
  always_comb begin
    coef_sel = '0;
    for (int j = 0; j < NUM_COEF; j++) begin
      if (32'(term_q) == j) coef_sel = coef_q[j];
    end
    dc_sel = '0;
    for (int j = 0; j < MAX_DEGREE; j++) begin
      if (32'(term_q) == j) dc_sel = dc_q[j];
    end
    case (op_q)
      OP_C: begin
        opa = coef_sel;
        opb = xi_q;
      end
      OP_D: begin
        opa = dc_sel;
        opb = xi_q;
      end
      default: begin
        opa = xi_q;
        opb = x_q;
      end
    endcase
  end

  // Derivative coefficient scaling for the preparation pass.
  logic [QW-1:0] coef_next;
  sat_t          dscale;
  always_comb begin
    coef_next = '0;
    for (int j = 0; j < NUM_COEF; j++) begin
      if (32'(term_q) == j) coef_next = coef_q[j];
    end
    dscale = clip52($signed({{(52-QW){coef_next[QW-1]}}, coef_next})
                    * $signed({{(52-TW){1'b0}}, term_q}));
  end

  // One 24x24 partial product per cycle.
  logic [23:0] pa, pb;
  logic [47:0] pp;
  logic [95:0] pp_sh;
  always_comb begin
    pa = mk_q[0] ? ma_q[47:24] : ma_q[23:0];
    pb = mk_q[1] ? mb_q[47:24] : mb_q[23:0];
    pp = pa * pb;
    case (mk_q)
      2'd0:    pp_sh = {48'd0, pp};
      2'd3:    pp_sh = {pp, 48'd0};
      default: pp_sh = {24'd0, pp, 24'd0};
    endcase
  end

  // Product rounding and the running sums.
  sat_t prod, p_sum, dp_sum;
  always_comb begin
    prod   = sign_clip(acc_q[95:32] + 64'(acc_q[31]), mneg_q);
    p_sum  = clip52(52'($signed(p_q)) + 52'($signed(prod.val)));
    dp_sum = clip52(52'($signed(dp_q)) + 52'($signed(prod.val)));
  end

  // One restoring division step per cycle.
  logic        nbit, ge;
  logic [48:0] rsh;
  logic [51:0] qsh;
  always_comb begin
    nbit = (dcnt_q >= DIV_FRAC) ? num_q[QW-1] : 1'b0;
    rsh  = {rem_q, nbit};
    ge   = rsh >= {1'b0, den_q};
    qsh  = {quo_q[50:0], ge};
  end

  // Final quotient rounding and the root update.
  logic [51:0] qfin;
  sat_t        qdiv, xnew;
  always_comb begin
    qfin = quo_q + 52'(!big_q && (rem_q >= den_q - rem_q));
    qdiv = sign_clip({12'd0, qfin}, dneg_q);
    xnew = clip52(52'($signed(x_q)) - 52'($signed(qdiv.val)));
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_PREP;
      S_PREP: if (term_q == TERM_LAST) state_d = S_STEP;
      S_STEP: state_d = (step_q == iter_cnt_q) ? S_IDLE : S_LOAD;
      S_LOAD: state_d = S_MUL;
      S_MUL:  if (mk_q == 2'd3) state_d = S_MACC;
      S_MACC: begin
        if (op_q == OP_C && term_q == TERM_LAST) state_d = S_CHK;
        else state_d = S_LOAD;
      end
      S_CHK:  state_d = (mag(dp_q) > DERIV_EPS) ? S_DIV : S_STEP;
      S_DIV:  if (dcnt_q == '0) state_d = S_UPD;
      S_UPD:  state_d = S_STEP;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      iter_cnt_q <= ITER_RESET;
      for (int j = 0; j < NUM_COEF; j++) coef_q[j] <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_STEP) && (step_q == iter_cnt_q);
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ITER_CNT) iter_cnt_q <= cfg_wdata_i[7:0];
        for (int j = 0; j < NUM_COEF; j++) begin
          if (cfg_idx_i == REG_COEF_0 + 3'(j)) coef_q[j] <= cfg_wdata_i;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_q    <= start_root_i;
          flag_q <= 1'b0;
          term_q <= TW'(1);
          step_q <= '0;
        end
      end
      S_PREP: begin
        for (int j = 0; j < MAX_DEGREE; j++) begin
          if (32'(term_q) == j + 1) dc_q[j] <= dscale.val;
        end
        flag_q <= flag_q | dscale.sat;
        term_q <= term_q + TW'(1);
      end
      S_STEP: begin
        p_q    <= '0;
        dp_q   <= '0;
        xi_q   <= Q_ONE;
        term_q <= '0;
        op_q   <= OP_C;
      end
      S_LOAD: begin
        ma_q   <= mag(opa);
        mb_q   <= mag(opb);
        mneg_q <= opa[QW-1] ^ opb[QW-1];
        mk_q   <= 2'd0;
        acc_q  <= '0;
      end
      S_MUL: begin
        acc_q <= acc_q + pp_sh;
        mk_q  <= mk_q + 2'd1;
      end
      S_MACC: begin
        case (op_q)
          OP_C: begin
            p_q    <= p_sum.val;
            flag_q <= flag_q | prod.sat | p_sum.sat;
            op_q   <= OP_D;
          end
          OP_D: begin
            dp_q   <= dp_sum.val;
            flag_q <= flag_q | prod.sat | dp_sum.sat;
            op_q   <= OP_X;
          end
          default: begin
            xi_q   <= prod.val;
            flag_q <= flag_q | prod.sat;
            term_q <= term_q + TW'(1);
            op_q   <= OP_C;
          end
        endcase
      end
      S_CHK: begin
        num_q  <= mag(p_q);
        den_q  <= mag(dp_q);
        dneg_q <= p_q[QW-1] ^ dp_q[QW-1];
        rem_q  <= '0;
        quo_q  <= '0;
        big_q  <= 1'b0;
        dcnt_q <= DIV_LAST;
        if (mag(dp_q) <= DERIV_EPS) step_q <= step_q + 8'd1;
      end
      S_DIV: begin
        rem_q  <= ge ? QW'(rsh - {1'b0, den_q}) : rsh[QW-1:0];
        if (dcnt_q >= DIV_FRAC) num_q <= {num_q[QW-2:0], 1'b0};
        if (qsh >= QUO_CAP) begin
          quo_q <= QUO_CAP;
          big_q <= 1'b1;
        end else begin
          quo_q <= qsh;
        end
        dcnt_q <= dcnt_q - 7'd1;
      end
      S_UPD: begin
        x_q    <= xnew.val;
        flag_q <= flag_q | qdiv.sat | xnew.sat;
        step_q <= step_q + 8'd1;
      end
      default: ;
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign refined_root_o = x_q;
  assign saturated_o    = flag_q;

  // Accepted start beats always enter the preparation pass.
  a_start_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> state_q == S_PREP) else $error("start not taken");

  // A result beat follows the last step and the block is then idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(state_q) == S_STEP) else $error("bad result beat");

  // The divider only runs after a derivative above threshold.
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_DIV) |-> $past(mag(dp_q) > DERIV_EPS))
    else $error("divide without valid derivative");

  // The multiplier takes four partial products per product.
  a_mul_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |=> ##4 state_q == S_MACC) else $error("multiply length");

endmodule

// File: test/root_refiner_checker.sv
`timescale 1ns / 1ps

// Watches the start, result and register channels of the root refiner, keeps
// its own copy of the coefficients and step count, predicts each refined root
// and compares it with the result beat.
module root_refiner_checker
  import pnr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_o,
  input  logic [QW-1:0] start_root_i,
  input  logic          done_o,
  input  logic [QW-1:0] refined_root_o,
  input  logic          saturated_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [QW-1:0] cfg_wdata_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            checked_o
);

  typedef longint          s64_t;
  typedef longint unsigned u64_t;

  typedef struct packed {
    logic          sat;
    logic [QW-1:0] root;
  } root_beat_t;

  localparam s64_t QMAX    = 64'sh7FFF_FFFF_FFFF;
  localparam s64_t QMIN    = -64'sh8000_0000_0000;
  localparam s64_t QUNIT   = 64'sh1_0000_0000;
  localparam u64_t EPS_RAW = 64'd42949;

  s64_t       coef_q [NUM_COEF];
  logic [7:0] newton_steps;
  bit         clipped;
  root_beat_t expected_roots [$];

  function automatic s64_t sx48(input logic [QW-1:0] v);
    return s64_t'($signed(v));
  endfunction

  function automatic u64_t mag_q(input s64_t a);
    return (a < 0) ? u64_t'(-a) : u64_t'(a);
  endfunction

  function automatic s64_t clip_q(input s64_t v);
    if (v > QMAX) begin
      clipped = 1'b1;
      return QMAX;
    end
    if (v < QMIN) begin
      clipped = 1'b1;
      return QMIN;
    end
    return v;
  endfunction

  // Attach a sign to a magnitude, clipping to the Q16.32 range.
  function automatic s64_t sign_q(input u64_t q, input bit neg);
    if (neg) begin
      if (q > u64_t'(64'h8000_0000_0000)) begin
        clipped = 1'b1;
        return QMIN;
      end
      return -s64_t'(q);
    end
    if (q > u64_t'(QMAX)) begin
      clipped = 1'b1;
      return QMAX;
    end
    return s64_t'(q);
  endfunction

  // Q16.32 product rounded to nearest, ties away from zero.
  function automatic s64_t qmul(input s64_t a, input s64_t b);
    u64_t ua, ub, ah, al, bh, bl, lo, mid, q;
    ua  = mag_q(a);
    ub  = mag_q(b);
    ah  = ua >> 32;
    al  = ua & 64'hFFFF_FFFF;
    bh  = ub >> 32;
    bl  = ub & 64'hFFFF_FFFF;
    lo  = al * bl;
    mid = ah * bl + al * bh;
    q   = ((ah * bh) << 32) + mid + (lo >> 32) + ((lo >> 31) & 64'd1);
    return sign_q(q, (a < 0) != (b < 0));
  endfunction

  // Restoring division of magnitudes with a capped quotient.
  function automatic s64_t qdiv(input s64_t num, input s64_t den);
    u64_t n, d, r, q, b;
    bit   big;
    n   = mag_q(num);
    d   = mag_q(den);
    r   = 0;
    q   = 0;
    big = 1'b0;
    if (d == 0) return 0;
    for (int i = 79; i >= 0; i--) begin
      b = (i >= 32) ? ((n >> (i - 32)) & 64'd1) : 64'd0;
      r = (r << 1) | b;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
      if (q >= (64'd1 << 50)) begin
        big = 1'b1;
        q   = 64'd1 << 50;
      end
    end
    if (!big && r >= d - r) q = q + 1;
    if (q == 0) return 0;
    return sign_q(q, (num < 0) != (den < 0));
  endfunction

  // Power series over the first n terms; powers beyond the last term are skipped.
  function automatic s64_t series_at(input s64_t c [NUM_COEF], input int n,
                                     input s64_t x);
    s64_t acc, xp;
    acc = 0;
    xp  = QUNIT;
    for (int i = 0; i < n; i++) begin
      acc = clip_q(acc + qmul(c[i], xp));
      if (i + 1 < n) xp = qmul(xp, x);
    end
    return acc;
  endfunction

  function automatic root_beat_t refine_root(input logic [QW-1:0] guess);
    s64_t       dcoef [NUM_COEF];
    s64_t       x, p, dp;
    root_beat_t beat;
    clipped = 1'b0;
    x       = sx48(guess);
    for (int i = 1; i < NUM_COEF; i++) dcoef[i-1] = clip_q(coef_q[i] * i);
    dcoef[NUM_COEF-1] = 0;
    for (int it = 0; it < newton_steps; it++) begin
      p  = series_at(coef_q, NUM_COEF, x);
      dp = series_at(dcoef, NUM_COEF - 1, x);
      if (mag_q(dp) > EPS_RAW) x = clip_q(x - qdiv(p, dp));
    end
    beat.root = x[QW-1:0];
    beat.sat  = clipped;
    return beat;
  endfunction

  // Track register writes, predict on accepted start beats, check result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    root_beat_t want;
    if (!rst_ni) begin
      foreach (coef_q[i]) coef_q[i] = 0;
      newton_steps = ITER_RESET;
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
      expected_roots.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < REG_ITER_CNT) coef_q[cfg_idx_i] = sx48(cfg_wdata_i);
        else if (cfg_idx_i == REG_ITER_CNT) newton_steps = cfg_wdata_i[7:0];
      end
      if (done_o) begin
        if (expected_roots.size() == 0) begin
          $error("result beat with no root expected: root %h sat %b",
                 refined_root_o, saturated_o);
          fail_count_o++;
        end else begin
          want = expected_roots.pop_front();
          checked_o++;
          if (refined_root_o !== want.root) begin
            $error("refined_root: expected %h, actual %h", want.root, refined_root_o);
            fail_count_o++;
          end
          if (saturated_o !== want.sat) begin
            $error("saturated: expected %b, actual %b", want.sat, saturated_o);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_o) expected_roots.push_back(refine_root(start_root_i));
      pending_o = expected_roots.size();
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pnr_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  logic          busy_o;
  logic [QW-1:0] start_root_i = '0;
  logic          done_o;
  logic [QW-1:0] refined_root_o;
  logic          saturated_o;
  logic          cfg_we_i = 1'b0;
  logic [2:0]    cfg_idx_i = '0;
  logic [QW-1:0] cfg_wdata_i = '0;
  int            fail_count, pending, checked;
  int            idle_pct;
  int            idle_cycles = 0;
  int            roots_sent;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  polynomial_newton_root_refiner_core DUT (.*);

  root_refiner_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .start_root_i, .done_o,
    .refined_root_o, .saturated_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Watchdog: ends the run after too long without any beat.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [QW-1:0] q_of(input int whole);
    return QW'(longint'(whole) <<< 32);
  endfunction

  function automatic logic [QW-1:0] rand_word();
    return QW'({$urandom, $urandom});
  endfunction

  // A value within about plus or minus 2^span_log2, in Q16.32.
  function automatic logic [QW-1:0] rand_near(input int span_log2);
    longint range;
    range = longint'(1) << (span_log2 + 33);
    return QW'(((longint'($urandom) << 32 | longint'($urandom)) & (range - 1))
               - (range >> 1));
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [QW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Steps are the low byte; the upper bits are junk the block must drop.
  task automatic write_steps(input logic [7:0] n);
    write_reg(REG_ITER_CNT, {40'(rand_word()), n});
  endtask

  task automatic send_root(input logic [QW-1:0] guess);
    @(negedge clk_i);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    start_i      = 1'b1;
    start_root_i = guess;
    @(negedge clk_i);
    start_i      = 1'b0;
    start_root_i = rand_word();
    roots_sent++;
  endtask

  // Hold the sender until every predicted root has come back.
  task automatic drain();
    @(negedge clk_i);
    while (pending != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic load_poly(input int mode);
    logic [QW-1:0] c;
    for (int i = 0; i < NUM_COEF; i++) begin
      case (mode)
        0: c = rand_near(2);
        1: c = rand_word();
        2: c = ($urandom_range(2) == 0) ? '0 : rand_near(4);
        default: c = ($urandom_range(1) != 0) ? Q_MAXV : Q_MINV;
      endcase
      write_reg(REG_COEF_0 + 3'(i), c);
    end
  endtask

  initial begin
    int steps_of [12];
    logic [QW-1:0] guess;
    steps_of    = '{1, 2, 3, 1, 0, 2, 4, 1, 2, 3, 1, 2};
    idle_pct    = 0;
    roots_sent  = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset polynomial is zero, so roots must not move.
    send_root(q_of(3));
    send_root(Q_MAXV);
    send_root(Q_MINV);
    drain();

    // x^2 - 2 at four steps, including a zero slope at the origin.
    write_reg(REG_COEF_0, q_of(-2));
    write_reg(REG_COEF_0 + 3'd2, Q_ONE);
    write_reg(3'd7, rand_word());
    send_root(q_of(1));
    send_root(q_of(-1));
    send_root('0);
    send_root(Q_MAXV);
    send_root(Q_MINV);
    send_root(48'd1);
    drain();

    // No steps returns the guess untouched.
    write_steps(8'd0);
    send_root(Q_MAXV);
    send_root(Q_MINV);
    send_root(48'hFFFF_FFFF_FFFF);
    drain();

    // Full quintic at extreme coefficients for one step, then random coefficients for many steps.
    for (int i = 0; i < NUM_COEF; i++) write_reg(REG_COEF_0 + 3'(i), Q_MAXV);
    write_steps(8'd1);
    send_root(q_of(2));
    send_root(q_of(-2));
    send_root(Q_MINV);
    drain();
    for (int i = 0; i < NUM_COEF; i++) write_reg(REG_COEF_0 + 3'(i), rand_near(2));
    write_steps(8'd255);
    send_root(rand_near(3));
    send_root(rand_word());
    drain();

    // Random phases: new polynomial, step count and idling per phase.
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 46 : 34;
      load_poly(ph % 4);
      write_steps(8'(steps_of[ph]));
      for (int k = 0; k < 76; k++) begin
        guess = ($urandom_range(3) == 0) ? rand_word() : rand_near(4);
        send_root(guess);
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("Run covered %0d guesses over zero, square, extreme and random polynomials,",
             roots_sent);
    $display("with 0 to 255 Newton steps and %0d root beats checked.", checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pnr_pkg.sv
rtl/core/polynomial_newton_root_refiner_core.sv
test/root_refiner_checker.sv
test/testbench.sv
